@@ rtl/core/cordic_atan2_phase_macros.svh @@
// ----------------------------------------------------------------------------
// cordic_atan2_phase assertion macros
// Concurrent assertion shorthands on aclk, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef CORDIC_ATAN2_PHASE_MACROS_SVH
`define CORDIC_ATAN2_PHASE_MACROS_SVH

// check on every rising edge once reset is released
`define CAP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check on every rising edge, reset included
`define CAP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/core/cap_pkg.sv @@
// ----------------------------------------------------------------------------
// cap_pkg
// Shared types and constants of the CORDIC atan2 phase pipeline.
// ----------------------------------------------------------------------------
package cap_pkg;

    localparam int PHASE_W     = 13;
    localparam int ITER_N      = 8;
    localparam int ITER_IDX_W  = 3;
    localparam int OUT_TDATA_W = 16;

    localparam logic signed [PHASE_W-1:0] HALF_PI = 13'sd1608;

    typedef struct packed {
        logic adv;
        logic vld;
    } stage_ctl_t;

    function automatic logic signed [PHASE_W-1:0] atan_entry(
        input logic [ITER_IDX_W-1:0] idx
    );
        logic signed [PHASE_W-1:0] val;
        unique case (idx)
            3'd0: val = 13'sd804;
            3'd1: val = 13'sd475;
            3'd2: val = 13'sd251;
            3'd3: val = 13'sd127;
            3'd4: val = 13'sd64;
            3'd5: val = 13'sd32;
            3'd6: val = 13'sd16;
            3'd7: val = 13'sd8;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/core/cap_prerot.sv @@
// ----------------------------------------------------------------------------
// cap_prerot
// Input stage: widen the sample and fold the left half plane by a quarter turn.
// ----------------------------------------------------------------------------
module cap_prerot #(
    parameter int SAMPLE_W = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cap_pkg::stage_ctl_t               ctl_i,
    input  logic [SAMPLE_W-1:0]               real_i,
    input  logic [SAMPLE_W-1:0]               imag_i,
    output logic                              valid_o,
    output logic signed [SAMPLE_W+1:0]        x_o,
    output logic signed [SAMPLE_W+1:0]        y_o,
    output logic signed [cap_pkg::PHASE_W-1:0] z_o
);

    localparam int W = SAMPLE_W + 2;

    logic signed [W-1:0]                x_ext, y_ext;
    logic signed [W-1:0]                x_next, y_next;
    logic signed [cap_pkg::PHASE_W-1:0] z_next;
    logic signed [W-1:0]                x_reg, y_reg;
    logic signed [cap_pkg::PHASE_W-1:0] z_reg;
    logic                               valid_reg;

    assign x_ext = {{2{real_i[SAMPLE_W-1]}}, real_i};
    assign y_ext = {{2{imag_i[SAMPLE_W-1]}}, imag_i};

    always_comb begin
        x_next = x_ext;
        y_next = y_ext;
        z_next = '0;
        if (x_ext < 0) begin
            if (y_ext >= 0) begin
                x_next = y_ext;
                y_next = -x_ext;
                z_next = cap_pkg::HALF_PI;
            end else begin
                x_next = -y_ext;
                y_next = x_ext;
                z_next = -cap_pkg::HALF_PI;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl_i.adv) begin
            valid_reg <= ctl_i.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_i.adv && ctl_i.vld) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign valid_o = valid_reg;
    assign x_o     = x_reg;
    assign y_o     = y_reg;
    assign z_o     = z_reg;

endmodule

@@ rtl/core/cap_iter.sv @@
// ----------------------------------------------------------------------------
// cap_iter
// One registered CORDIC vectoring micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module cap_iter #(
    parameter int W     = 18,
    parameter int SHIFT = 0
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  cap_pkg::stage_ctl_t                ctl_i,
    input  logic signed [W-1:0]                x_i,
    input  logic signed [W-1:0]                y_i,
    input  logic signed [cap_pkg::PHASE_W-1:0] z_i,
    output logic                               valid_o,
    output logic signed [W-1:0]                x_o,
    output logic signed [W-1:0]                y_o,
    output logic signed [cap_pkg::PHASE_W-1:0] z_o
);

    logic signed [W-1:0]                xs, ys;
    logic signed [W-1:0]                x_next, y_next;
    logic signed [cap_pkg::PHASE_W-1:0] z_next, atan_val;
    logic signed [W-1:0]                x_reg, y_reg;
    logic signed [cap_pkg::PHASE_W-1:0] z_reg;
    logic                               valid_reg;

    assign xs       = x_i >>> SHIFT;
    assign ys       = y_i >>> SHIFT;
    assign atan_val = cap_pkg::atan_entry(cap_pkg::ITER_IDX_W'(SHIFT));

    always_comb begin
        if (y_i >= 0) begin
            x_next = x_i + ys;
            y_next = y_i - xs;
            z_next = z_i + atan_val;
        end else begin
            x_next = x_i - ys;
            y_next = y_i + xs;
            z_next = z_i - atan_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl_i.adv) begin
            valid_reg <= ctl_i.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_i.adv && ctl_i.vld) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign valid_o = valid_reg;
    assign x_o     = x_reg;
    assign y_o     = y_reg;
    assign z_o     = z_reg;

endmodule

@@ rtl/core/cap_delay.sv @@
// ----------------------------------------------------------------------------
// cap_delay
// Per-word phase delay line and the output register of the result stream.
// ----------------------------------------------------------------------------
module cap_delay #(
    parameter int DELAY = 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  cap_pkg::stage_ctl_t                ctl_i,
    input  logic signed [cap_pkg::PHASE_W-1:0] phase_i,
    output logic                               valid_o,
    output logic signed [cap_pkg::PHASE_W-1:0] phase_o
);

    logic signed [cap_pkg::PHASE_W-1:0] line_reg [DELAY];
    logic signed [cap_pkg::PHASE_W-1:0] phase_reg;
    logic                               valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            for (int i = 0; i < DELAY; i++) begin
                line_reg[i] <= '0;
            end
        end else if (ctl_i.adv) begin
            valid_reg <= ctl_i.vld;
            if (ctl_i.vld) begin
                for (int i = DELAY - 1; i > 0; i--) begin
                    line_reg[i] <= line_reg[i-1];
                end
                line_reg[0] <= phase_i;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_i.adv && ctl_i.vld) begin
            phase_reg <= line_reg[DELAY-1];
        end
    end

    assign valid_o = valid_reg;
    assign phase_o = phase_reg;

endmodule

@@ rtl/core/cordic_atan2_phase.sv @@
// Stages: one input stage, eight rotation stages, the phase delay line, one output stage.
// Throughput: one word per cycle while the output is not stalled.
// A stall on m_axis_tready holds every stage together; nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and zeroes the phase delay line,
// so the first DELAY result words carry phase 0.
// ----------------------------------------------------------------------------
// cordic_atan2_phase
// Phase of a complex sample stream by pipelined 8-step CORDIC vectoring.
// ----------------------------------------------------------------------------
`include "cordic_atan2_phase_macros.svh"

module cordic_atan2_phase #(
    parameter int SAMPLE_W = 16,
    parameter int DELAY    = 1
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // real_in, imag_in
    input  logic [((2*SAMPLE_W+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // phase_out
    output logic [cap_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

    localparam int W = SAMPLE_W + 2;

    logic                               adv;
    logic                               valid_s [cap_pkg::ITER_N+1];
    logic signed [W-1:0]                x_s     [cap_pkg::ITER_N+1];
    logic signed [W-1:0]                y_s     [cap_pkg::ITER_N+1];
    logic signed [cap_pkg::PHASE_W-1:0] z_s     [cap_pkg::ITER_N+1];
    logic signed [cap_pkg::PHASE_W-1:0] phase;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    cap_prerot #(
        .SAMPLE_W (SAMPLE_W)
    ) u_prerot (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   ({adv, s_axis_tvalid}),
        .real_i  (s_axis_tdata[SAMPLE_W-1:0]),
        .imag_i  (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .valid_o (valid_s[0]),
        .x_o     (x_s[0]),
        .y_o     (y_s[0]),
        .z_o     (z_s[0])
    );

    for (genvar g = 0; g < cap_pkg::ITER_N; g++) begin : g_iter
        cap_iter #(
            .W     (W),
            .SHIFT (g)
        ) u_iter (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl_i   ({adv, valid_s[g]}),
            .x_i     (x_s[g]),
            .y_i     (y_s[g]),
            .z_i     (z_s[g]),
            .valid_o (valid_s[g+1]),
            .x_o     (x_s[g+1]),
            .y_o     (y_s[g+1]),
            .z_o     (z_s[g+1])
        );
    end

    cap_delay #(
        .DELAY (DELAY)
    ) u_delay (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   ({adv, valid_s[cap_pkg::ITER_N]}),
        .phase_i (z_s[cap_pkg::ITER_N]),
        .valid_o (m_axis_tvalid),
        .phase_o (phase)
    );

    assign m_axis_tdata = {{(cap_pkg::OUT_TDATA_W - cap_pkg::PHASE_W){1'b0}}, phase};

    `CAP_ASSERT(a_accept_enters, s_axis_tvalid && s_axis_tready |=> valid_s[0], "accepted word did not enter the pipeline")
    `CAP_ASSERT(a_prerot_right_half, valid_s[0] |-> !x_s[0][W-1], "pre-rotation left x negative")
    `CAP_ASSERT(a_final_x_pos, valid_s[cap_pkg::ITER_N] |-> !x_s[cap_pkg::ITER_N][W-1], "final x negative")
    `CAP_ASSERT(a_angle_range, valid_s[cap_pkg::ITER_N] |-> (z_s[cap_pkg::ITER_N] <= 13'sd3385 && z_s[cap_pkg::ITER_N] >= -13'sd3385), "angle out of range")

endmodule

@@ tb/sv/cordic_atan2_phase_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cordic_atan2_phase_checker
// Watches both stream channels of the CORDIC phase block. Every accepted
// sample word is vectored here to its own angle and pushed through a
// delay line. The word that leaves the line is queued as an owed phase.
// Every accepted result word is compared with the oldest owed phase.
// ----------------------------------------------------------------------------
module cordic_atan2_phase_checker #(
    parameter int SAMPLE_W = 16,
    parameter int DELAY    = 1
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    // real_in, imag_in
    input  logic [((2*SAMPLE_W+7)/8)*8-1:0]       s_tdata,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    // phase_out
    input  logic [cap_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output int                                    mismatch_count,
    output int                                    phases_owed
);

    logic [cap_pkg::PHASE_W-1:0] phase_line [DELAY];
    logic [cap_pkg::PHASE_W-1:0] owed_phase [$];

    function automatic longint arctan_step(input int i);
        case (i)
            0:       return 804;
            1:       return 475;
            2:       return 251;
            3:       return 127;
            4:       return 64;
            5:       return 32;
            6:       return 16;
            default: return 8;
        endcase
    endfunction

    function automatic logic [cap_pkg::PHASE_W-1:0] vector_phase(
        input logic signed [SAMPLE_W-1:0] re,
        input logic signed [SAMPLE_W-1:0] im
    );
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint hold;
        x = re;
        y = im;
        z = 0;
        // quarter turn into the right half plane
        if (x < 0) begin
            hold = x;
            if (y >= 0) begin
                x = y;
                y = -hold;
                z = cap_pkg::HALF_PI;
            end else begin
                x = -y;
                y = hold;
                z = -cap_pkg::HALF_PI;
            end
        end
        for (int i = 0; i < cap_pkg::ITER_N; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_step(i);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_step(i);
            end
        end
        return z[cap_pkg::PHASE_W-1:0];
    endfunction

    always @(posedge aclk) begin
        logic [cap_pkg::PHASE_W-1:0] want;
        logic [cap_pkg::PHASE_W-1:0] got;
        if (!aresetn) begin
            for (int i = 0; i < DELAY; i++) phase_line[i] = '0;
            owed_phase.delete();
            mismatch_count <= 0;
        end else begin
            // check results before queuing this edge's sample
            if (m_tvalid && m_tready) begin
                got = m_tdata[cap_pkg::PHASE_W-1:0];
                if (owed_phase.size() == 0) begin
                    $display("%0t unexpected phase word: expected none, got %0d",
                             $time, $signed(got));
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = owed_phase.pop_front();
                    if (got !== want) begin
                        $display("%0t phase mismatch: expected %0d, got %0d",
                                 $time, $signed(want), $signed(got));
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                owed_phase.push_back(phase_line[DELAY-1]);
                for (int i = DELAY - 1; i > 0; i--) phase_line[i] = phase_line[i-1];
                phase_line[0] = vector_phase(s_tdata[SAMPLE_W-1:0],
                                             s_tdata[2*SAMPLE_W-1:SAMPLE_W]);
            end
        end
        phases_owed <= owed_phase.size();
    end

endmodule

@@ tb/sv/cordic_atan2_phase_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cordic_atan2_phase_tb
// Drives complex sample words into the CORDIC phase block: a directed set
// of axis, quadrant and extreme samples, then random samples, with random
// idle bursts on the input and stall bursts on the output. The checker
// beside the block predicts and compares every phase word.
// ----------------------------------------------------------------------------
module cordic_atan2_phase_tb;

    localparam int SAMPLE_W = 16;
    localparam int DELAY    = 1;
    localparam int RANDOM_N = 1500;
    localparam int QUIET_AT = 1300;

    logic                            aclk;
    logic                            aresetn       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // real_in, imag_in
    logic [31:0]                     s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // phase_out
    logic [cap_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    int mismatch_count;
    int phases_owed;
    bit quiet = 1'b0;

    cordic_atan2_phase #(
        .SAMPLE_W (SAMPLE_W),
        .DELAY    (DELAY)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    cordic_atan2_phase_checker #(
        .SAMPLE_W (SAMPLE_W),
        .DELAY    (DELAY)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_axis_tvalid),
        .s_tready       (s_axis_tready),
        .s_tdata        (s_axis_tdata),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_tdata        (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .phases_owed    (phases_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // output stall bursts
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = int'($urandom_range(1, 19)) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {im, re};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    function automatic logic [15:0] edge_value();
        case ($urandom_range(0, 6))
            0:       return 16'h8000;
            1:       return 16'h8001;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            5:       return 16'h7FFF;
            default: return 16'h7FFE;
        endcase
    endfunction

    function automatic logic [15:0] any_value();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 16'hFFFF));
            1:       return 16'($urandom_range(0, 63) - 32);
            2:       return edge_value();
            default: return 16'($urandom_range(0, 4095) - 2048);
        endcase
    endfunction

    initial begin
        logic [15:0] re;
        logic [15:0] im;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero sample, the axes and the quadrant boundaries
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd1000);
        send_sample(16'sd0, -16'sd1000);
        send_sample(16'sd1000, 16'sd0);
        send_sample(-16'sd1000, 16'sd0);
        send_sample(-16'sd1000, 16'sd1);
        send_sample(-16'sd1000, -16'sd1);
        send_sample(16'sd1000, 16'sd1000);
        send_sample(-16'sd1000, 16'sd1000);
        send_sample(-16'sd1000, -16'sd1000);
        send_sample(16'sd1000, -16'sd1000);
        send_sample(-16'sd1, 16'sd0);
        send_sample(-16'sd1, -16'sd1);
        // extremes of both fields
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sd0);
        send_sample(16'sd0, 16'sh8000);
        send_sample(16'sh7FFF, 16'sd0);
        send_sample(16'sd0, 16'sh7FFF);
        send_sample(16'sd1, 16'sd1);
        send_sample(16'sh5555, 16'shAAAA);
        send_sample(16'shAAAA, 16'sh5555);

        for (int n = 0; n < RANDOM_N; n++) begin
            if (n == RANDOM_N / 2) begin
                // hold input until every owed phase is out
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
                while (phases_owed != 0) @(posedge aclk);
            end
            if (n == QUIET_AT) quiet = 1'b1;
            re = any_value();
            im = any_value();
            send_sample(re, im);
        end
        s_axis_tvalid <= 1'b0;

        @(posedge aclk);
        while (phases_owed != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && phases_owed == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/cap_pkg.sv
rtl/core/cap_prerot.sv
rtl/core/cap_iter.sv
rtl/core/cap_delay.sv
rtl/core/cordic_atan2_phase.sv
tb/sv/cordic_atan2_phase_checker.sv
tb/sv/cordic_atan2_phase_tb.sv
